/* rtl/assert_macros.svh */
// Assertion macros shared by the zero-run symbol histogram RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ZRSH_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ZRSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ZRSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/zrsh_pkg.sv */
// Package for the zero-run symbol histogram: sizes, codes, queue entry type
// and saturation helpers. No dependencies.
package zrsh_pkg;

  localparam int SYMBOLS     = 256;
  localparam int RUN_BINS    = 16;
  localparam int COUNT_WIDTH = 32;

  localparam int MAIN_DEPTH = SYMBOLS + RUN_BINS;
  localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
  localparam int AFT_AW     = $clog2(SYMBOLS);
  localparam int BIN_W      = $clog2(MAIN_DEPTH + 1);
  localparam int CALC_W     = (BIN_W > 9) ? BIN_W : 9;
  localparam int CLS_W      = $clog2(RUN_BINS + 1);

  localparam int OP_W    = 2;
  localparam int VALUE_W = 8;
  localparam int INDEX_W = 9;
  localparam int OUT_W   = 32;

  localparam int SYMCFG_W = 9;
  localparam int RUNCFG_W = 5;
  localparam logic [SYMCFG_W-1:0] SYMBOL_COUNT_RST = 9'd256;
  localparam logic [RUNCFG_W-1:0] RUN_CLASSES_RST  = 5'd16;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int REG_BIT  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    REG_SYMBOL_COUNT = 1'b0,
    REG_RUN_CLASSES  = 1'b1
  } reg_idx_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_W-1:0]       out_count_t;

  typedef struct packed {
    logic               main_inc;
    logic               main_rd;
    logic [MAIN_AW-1:0] main_addr;
    logic               after_inc;
    logic               after_rd;
    logic [AFT_AW-1:0]  after_addr;
    out_count_t         total;
    out_count_t         zeros;
    logic               err;
  } qentry_t;

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic out_count_t out_sat(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_W-1:0];
  endfunction

endpackage

/* rtl/zrsh_if.sv */
// Input and result channel interfaces (valid/ready plus payload).
// Depends on zrsh_pkg for field widths.
interface zrsh_in_if;
  logic                         valid;
  logic                         ready;
  logic [zrsh_pkg::OP_W-1:0]    operation;
  logic [zrsh_pkg::VALUE_W-1:0] value;
  logic [zrsh_pkg::INDEX_W-1:0] read_index;

  modport source(output valid, operation, value, read_index, input ready);
  modport sink(input valid, operation, value, read_index, output ready);
endinterface

interface zrsh_out_if;
  logic                       valid;
  logic                       ready;
  logic [zrsh_pkg::OUT_W-1:0] main_count;
  logic [zrsh_pkg::OUT_W-1:0] after_run_count;
  logic [zrsh_pkg::OUT_W-1:0] total_values;
  logic [zrsh_pkg::OUT_W-1:0] zero_values;
  logic                       value_error;

  modport source(output valid, main_count, after_run_count, total_values, zero_values,
                 value_error, input ready);
  modport sink(input valid, main_count, after_run_count, total_values, zero_values,
               value_error, output ready);
endinterface

/* rtl/zrsh_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module zrsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_r <= mem_r[raddr_i];
    end
  end

  assign rdata_o = rdata_r;

endmodule

/* rtl/zrsh_front.sv */
// Front end: accepts input transfers, keeps run length and value counters,
// and turns each item into histogram actions. Depends on zrsh_pkg, zrsh_if.
module zrsh_front (
  input  logic                            clk,
  input  logic                            rst_n,
  zrsh_in_if.sink                         in_ch,
  input  logic [zrsh_pkg::SYMCFG_W-1:0]   symbol_count_i,
  input  logic [zrsh_pkg::RUNCFG_W-1:0]   run_classes_i,
  input  logic                            q_full_i,
  input  logic                            clearing_i,
  output logic                            push_o,
  output zrsh_pkg::qentry_t               entry_o
);
  import zrsh_pkg::*;

  count_t run_r, run_nxt;
  count_t total_r, total_nxt;
  count_t zero_r, zero_nxt;

  logic [CALC_W-1:0]  eff_sym;
  logic [CLS_W-1:0]   eff_cls;
  logic [CLS_W-1:0]   cls;
  logic [MAIN_AW-1:0] run_bin;
  logic               v_err;
  logic               accept;

  assign in_ch.ready = !q_full_i && !clearing_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_o      = accept;

  always_comb begin
    if (CALC_W'(symbol_count_i) < CALC_W'(2)) begin
      eff_sym = CALC_W'(2);
    end else if (32'(symbol_count_i) > 32'(SYMBOLS)) begin
      eff_sym = CALC_W'(SYMBOLS);
    end else begin
      eff_sym = CALC_W'(symbol_count_i);
    end

    if (run_classes_i == '0) begin
      eff_cls = CLS_W'(1);
    end else if (32'(run_classes_i) > 32'(RUN_BINS)) begin
      eff_cls = CLS_W'(RUN_BINS);
    end else begin
      eff_cls = CLS_W'(run_classes_i);
    end

    cls     = (64'(run_r) >= 64'(eff_cls)) ? eff_cls : CLS_W'(run_r);
    run_bin = MAIN_AW'(eff_sym) + MAIN_AW'(cls) - MAIN_AW'(1);
    v_err   = 32'(in_ch.value) >= 32'(eff_sym);
  end

  always_comb begin
    run_nxt   = run_r;
    total_nxt = total_r;
    zero_nxt  = zero_r;
    entry_o   = '0;

    case (op_t'(in_ch.operation))
      OP_PUT: begin
        if (v_err) begin
          entry_o.err = 1'b1;
        end else begin
          total_nxt = sat_inc(total_r);
          if (in_ch.value == '0) begin
            zero_nxt = sat_inc(zero_r);
            run_nxt  = sat_inc(run_r);
          end else if (run_r != '0) begin
            entry_o.main_inc   = 1'b1;
            entry_o.main_addr  = run_bin;
            entry_o.after_inc  = 1'b1;
            entry_o.after_addr = AFT_AW'(in_ch.value);
            run_nxt            = '0;
          end else begin
            entry_o.main_inc  = 1'b1;
            entry_o.main_addr = MAIN_AW'(in_ch.value);
          end
        end
      end
      OP_FINISH: begin
        if (run_r != '0) begin
          entry_o.main_inc  = 1'b1;
          entry_o.main_addr = run_bin;
          run_nxt           = '0;
        end
      end
      OP_READ: begin
        entry_o.main_rd    = 32'(in_ch.read_index) < 32'(MAIN_DEPTH);
        entry_o.after_rd   = 32'(in_ch.read_index) < 32'(SYMBOLS);
        entry_o.main_addr  = MAIN_AW'(in_ch.read_index);
        entry_o.after_addr = AFT_AW'(in_ch.read_index);
      end
      default: begin
      end
    endcase

    entry_o.total = out_sat(total_nxt);
    entry_o.zeros = out_sat(zero_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      total_r <= '0;
      zero_r  <= '0;
    end else if (accept) begin
      run_r   <= run_nxt;
      total_r <= total_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

/* rtl/zrsh_queue.sv */
// Short FIFO of classified items between the front and back ends.
// Depends on zrsh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module zrsh_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  zrsh_pkg::qentry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  output zrsh_pkg::qentry_t head_o,
  input  logic              pop_i
);
  import zrsh_pkg::*;

  qentry_t         entries_r [QUEUE_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign full_o  = cnt_r == Q_CW'(QUEUE_DEPTH);
  assign valid_o = cnt_r != '0;
  assign head_o  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries_r[wr_ptr_r] <= entry_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `ZRSH_ASSERT_IMP(a_no_push_full, full_o, !push_i, "push into full queue")
  `ZRSH_ASSERT_IMP(a_no_pop_empty, !valid_o, !pop_i, "pop from empty queue")
  `ZRSH_ASSERT_NEXT(a_cnt_grow, push_i && !pop_i, cnt_r == Q_CW'($past(cnt_r) + 1'b1), "queue count did not grow on push")

endmodule

/* rtl/zrsh_back.sv */
// Back end: clears both histograms after reset, then does read-modify-write
// with one-entry forwarding per RAM and holds the result register.
// Depends on zrsh_pkg, zrsh_if, zrsh_ram and assert_macros.svh.
`include "assert_macros.svh"
module zrsh_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid_i,
  input  zrsh_pkg::qentry_t q_head_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  zrsh_out_if.source        out_ch
);
  import zrsh_pkg::*;

  logic               clearing_r;
  logic [MAIN_AW-1:0] clr_addr_r;

  logic    b_valid_r;
  qentry_t b_entry_r;
  logic    b_fire;
  logic    a_pop;

  logic               main_fwd_v_r;
  logic [MAIN_AW-1:0] main_fwd_addr_r;
  count_t             main_fwd_data_r;
  logic               aft_fwd_v_r;
  logic [AFT_AW-1:0]  aft_fwd_addr_r;
  count_t             aft_fwd_data_r;

  count_t main_rdata, aft_rdata;
  count_t main_cur, aft_cur;
  count_t main_new, aft_new;

  logic               main_we;
  logic [MAIN_AW-1:0] main_waddr;
  count_t             main_wdata;
  logic               aft_we;
  logic [AFT_AW-1:0]  aft_waddr;
  count_t             aft_wdata;

  logic       out_valid_r;
  out_count_t out_main_r, out_aft_r, out_total_r, out_zeros_r;
  logic       out_err_r;

  assign clearing_o = clearing_r;
  assign b_fire     = b_valid_r && (!out_valid_r || out_ch.ready);
  assign a_pop      = q_valid_i && !clearing_r && (!b_valid_r || b_fire);
  assign q_pop_o    = a_pop;

  zrsh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAIN_DEPTH)) u_main_ram (
    .clk     (clk),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .re_i    (a_pop),
    .raddr_i (q_head_i.main_addr),
    .rdata_o (main_rdata)
  );

  zrsh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYMBOLS)) u_aft_ram (
    .clk     (clk),
    .we_i    (aft_we),
    .waddr_i (aft_waddr),
    .wdata_i (aft_wdata),
    .re_i    (a_pop),
    .raddr_i (q_head_i.after_addr),
    .rdata_o (aft_rdata)
  );

  always_comb begin
    main_cur = (main_fwd_v_r && main_fwd_addr_r == b_entry_r.main_addr) ?
               main_fwd_data_r : main_rdata;
    aft_cur  = (aft_fwd_v_r && aft_fwd_addr_r == b_entry_r.after_addr) ?
               aft_fwd_data_r : aft_rdata;
    main_new = sat_inc(main_cur);
    aft_new  = sat_inc(aft_cur);

    if (clearing_r) begin
      main_we    = 1'b1;
      main_waddr = clr_addr_r;
      main_wdata = '0;
      aft_we     = 32'(clr_addr_r) < 32'(SYMBOLS);
      aft_waddr  = AFT_AW'(clr_addr_r);
      aft_wdata  = '0;
    end else begin
      main_we    = b_fire && b_entry_r.main_inc;
      main_waddr = b_entry_r.main_addr;
      main_wdata = main_new;
      aft_we     = b_fire && b_entry_r.after_inc;
      aft_waddr  = b_entry_r.after_addr;
      aft_wdata  = aft_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      b_valid_r    <= 1'b0;
      main_fwd_v_r <= 1'b0;
      aft_fwd_v_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == MAIN_AW'(MAIN_DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (a_pop) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (!clearing_r && main_we) begin
        main_fwd_v_r <= 1'b1;
      end
      if (!clearing_r && aft_we) begin
        aft_fwd_v_r <= 1'b1;
      end
      if (b_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_pop) begin
      b_entry_r <= q_head_i;
    end
    if (!clearing_r && main_we) begin
      main_fwd_addr_r <= main_waddr;
      main_fwd_data_r <= main_wdata;
    end
    if (!clearing_r && aft_we) begin
      aft_fwd_addr_r <= aft_waddr;
      aft_fwd_data_r <= aft_wdata;
    end
    if (b_fire) begin
      out_main_r  <= b_entry_r.main_rd ? out_sat(main_cur) : '0;
      out_aft_r   <= b_entry_r.after_rd ? out_sat(aft_cur) : '0;
      out_total_r <= b_entry_r.total;
      out_zeros_r <= b_entry_r.zeros;
      out_err_r   <= b_entry_r.err;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.main_count      = out_main_r;
  assign out_ch.after_run_count = out_aft_r;
  assign out_ch.total_values    = out_total_r;
  assign out_ch.zero_values     = out_zeros_r;
  assign out_ch.value_error     = out_err_r;

  `ZRSH_ASSERT_IMP(a_no_pop_clearing, clearing_r, !a_pop, "item issued during clear pass")
  `ZRSH_ASSERT_NEXT(a_fwd_nonzero, b_fire && b_entry_r.main_inc, main_fwd_v_r && (main_fwd_data_r != '0), "increment wrote a zero count")
  `ZRSH_ASSERT_IMP(a_clear_end, $fell(clearing_r), $past(clr_addr_r) == MAIN_AW'(MAIN_DEPTH - 1), "clear pass ended early")

endmodule

/* rtl/zero_run_symbol_histogram_top.sv */
// Path: queue, RAM read, result register; one item per cycle while out_ch.ready is high.
// The result register and the 4-entry queue let input transfers continue while a result waits.
// The RAM read-modify-write path with one-entry forwarding sets the one-per-cycle rate.
// Reset (synchronous, rst_n low) clears the counters and loads the default config; then a
// clear pass zeroes both histograms with in_ch.ready low (config writes still taken).
module zero_run_symbol_histogram_top (
  input  logic                        clk,
  input  logic                        rst_n,
  zrsh_in_if.sink                     in_ch,
  zrsh_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zrsh_pkg::CFG_AW-1:0] paddr,
  input  logic [zrsh_pkg::CFG_DW-1:0] pwdata,
  output logic [zrsh_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import zrsh_pkg::*;

  logic [SYMCFG_W-1:0] symbol_count_r;
  logic [RUNCFG_W-1:0] run_classes_r;
  logic                cfg_we;
  reg_idx_t            reg_idx;

  logic    push;
  qentry_t entry;
  logic    q_full;
  logic    q_valid;
  qentry_t q_head;
  logic    q_pop;
  logic    clearing;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[REG_BIT]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= SYMBOL_COUNT_RST;
      run_classes_r  <= RUN_CLASSES_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SYMBOL_COUNT: symbol_count_r <= pwdata[SYMCFG_W-1:0];
        REG_RUN_CLASSES:  run_classes_r  <= pwdata[RUNCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYMBOL_COUNT: prdata = CFG_DW'(symbol_count_r);
      REG_RUN_CLASSES:  prdata = CFG_DW'(run_classes_r);
      default:          prdata = '0;
    endcase
  end

  zrsh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .symbol_count_i (symbol_count_r),
    .run_classes_i  (run_classes_r),
    .q_full_i       (q_full),
    .clearing_i     (clearing),
    .push_o         (push),
    .entry_o        (entry)
  );

  zrsh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  zrsh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .out_ch     (out_ch)
  );

endmodule

/* tb/zero_run_symbol_histogram_top_tb.sv */
// Self-checking bench for zero_run_symbol_histogram_top: random and directed put, finish, read
// transfers, checked against a local model of the histograms. Uses zrsh_pkg, zrsh_in_if, zrsh_out_if.
module zero_run_symbol_histogram_top_tb;
  import zrsh_pkg::*;

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 200;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } hist_item_t;

  typedef struct {
    logic [OUT_W-1:0] main_cnt;
    logic [OUT_W-1:0] after_cnt;
    logic [OUT_W-1:0] total;
    logic [OUT_W-1:0] zeros;
    logic             err;
  } hist_counts_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic [OP_W-1:0]    in_op = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic [INDEX_W-1:0] in_index = '0;
  logic               res_ready = 1'b0;
  logic               in_taken = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  zrsh_in_if  in_ch();
  zrsh_out_if out_ch();

  assign in_ch.valid      = in_valid;
  assign in_ch.operation  = in_op;
  assign in_ch.value      = in_value;
  assign in_ch.read_index = in_index;
  assign out_ch.ready     = res_ready;

  zero_run_symbol_histogram_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // model state
  count_t                main_hist [MAIN_DEPTH];
  count_t                after_hist [SYMBOLS];
  count_t                run_len;
  count_t                total_cnt;
  count_t                zero_cnt;
  logic [SYMCFG_W-1:0]   sym_cfg = SYMBOL_COUNT_RST;
  logic [RUNCFG_W-1:0]   cls_cfg = RUN_CLASSES_RST;

  hist_item_t   pending_items[$];
  hist_counts_t expected_counts[$];

  int errors = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_done = 0;
  int hold_left = 0;

  function automatic count_t bump(input count_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int live_symbols();
    if (sym_cfg < 2) return 2;
    if (sym_cfg > SYMBOLS) return SYMBOLS;
    return int'(sym_cfg);
  endfunction

  function automatic int live_classes();
    if (cls_cfg < 1) return 1;
    if (cls_cfg > RUN_BINS) return RUN_BINS;
    return int'(cls_cfg);
  endfunction

  function automatic void close_run();
    int cls;
    int bin;
    if (run_len == 0) return;
    cls = live_classes();
    if (run_len < count_t'(cls)) cls = int'(run_len);
    bin = live_symbols() + cls - 1;
    if (bin < MAIN_DEPTH) main_hist[bin] = bump(main_hist[bin]);
    run_len = '0;
  endfunction

  function automatic hist_counts_t count_item(input hist_item_t it);
    hist_counts_t r;
    r = '{default: '0};
    if (it.op == OP_PUT) begin
      if (int'(it.value) >= live_symbols()) begin
        r.err = 1'b1;
      end else begin
        total_cnt = bump(total_cnt);
        if (it.value == 0) begin
          zero_cnt = bump(zero_cnt);
          run_len = bump(run_len);
        end else if (run_len != 0) begin
          close_run();
          after_hist[it.value] = bump(after_hist[it.value]);
        end else begin
          main_hist[it.value] = bump(main_hist[it.value]);
        end
      end
    end else if (it.op == OP_FINISH) begin
      close_run();
    end else if (it.op == OP_READ) begin
      if (it.index < MAIN_DEPTH) r.main_cnt = main_hist[it.index];
      if (it.index < SYMBOLS) r.after_cnt = after_hist[it.index];
    end
    r.total = total_cnt;
    r.zeros = zero_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // result check and prediction at the rising edge
  always @(posedge clk) begin
    hist_counts_t want;
    hist_item_t   it;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && res_ready) begin
        if (expected_counts.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, got main %0h after %0h total %0h zeros %0h err %0b",
                   $time, out_ch.main_count, out_ch.after_run_count, out_ch.total_values,
                   out_ch.zero_values, out_ch.value_error);
        end else begin
          want = expected_counts.pop_front();
          check_field("main_count", want.main_cnt, out_ch.main_count);
          check_field("after_run_count", want.after_cnt, out_ch.after_run_count);
          check_field("total_values", want.total, out_ch.total_values);
          check_field("zero_values", want.zeros, out_ch.zero_values);
          check_field("value_error", OUT_W'(want.err), OUT_W'(out_ch.value_error));
        end
      end
      in_taken = in_valid && (in_ch.ready === 1'b1);
      if (in_taken) begin
        it.op = in_op;
        it.value = in_value;
        it.index = in_index;
        want = count_item(it);
        expected_counts.insert(expected_counts.size(), want);
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    hist_item_t it;
    if (!(in_valid && !in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_op <= it.op;
        in_value <= it.value;
        in_index <= it.index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input int value, input int index);
    hist_item_t it;
    it.op = op;
    it.value = VALUE_W'(value);
    it.index = INDEX_W'(index);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_random(input int n);
    int made;
    int r;
    int len;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        len = $urandom_range(40, 1);
        repeat (len) push_item(OP_PUT, 0, $urandom_range(511));
        made += len;
      end else begin
        if (r < 58) begin
          r = $urandom_range(99);
          if (r < 35) push_item(OP_PUT, 0, $urandom_range(511));
          else if (r < 90) push_item(OP_PUT, $urandom_range(live_symbols() - 1),
                                     $urandom_range(511));
          else push_item(OP_PUT, $urandom_range(255), $urandom_range(511));
        end else if (r < 68) begin
          push_item(OP_FINISH, $urandom_range(255), $urandom_range(511));
        end else if (r < 96) begin
          push_item(OP_READ, $urandom_range(255),
                    ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(271));
        end else begin
          push_item(OP_SPARE, $urandom_range(255), $urandom_range(511));
        end
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || (in_valid && !in_taken) || expected_counts.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << REG_BIT;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_SYMBOL_COUNT) sym_cfg = data[SYMCFG_W-1:0];
    else cls_cfg = data[RUNCFG_W-1:0];
  endtask

  task automatic start_phase(input int sym, input int cls, input int idle, input int stall);
    wait_drained();
    write_reg(REG_SYMBOL_COUNT, CFG_DW'(sym));
    write_reg(REG_RUN_CLASSES, CFG_DW'(cls));
    idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    for (int i = 0; i < MAIN_DEPTH; i++) main_hist[i] = '0;
    for (int i = 0; i < SYMBOLS; i++) after_hist[i] = '0;
    run_len = '0;
    total_cnt = '0;
    zero_cnt = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: runs, after-run values, empty finish, spare code, read extremes
    start_phase(256, 16, 0, 0);
    push_item(OP_READ, 0, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_PUT, 5, 0);
    push_item(OP_PUT, 255, 0);
    push_item(OP_PUT, 1, 0);
    push_item(OP_FINISH, 0, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_FINISH, 0, 0);
    push_item(OP_SPARE, 255, 511);
    push_item(OP_READ, 0, 1);
    push_item(OP_READ, 0, 5);
    push_item(OP_READ, 0, 255);
    push_item(OP_READ, 0, 256);
    push_item(OP_READ, 0, 258);
    push_item(OP_READ, 0, 271);
    push_item(OP_READ, 0, 272);
    push_item(OP_READ, 255, 511);
    push_item(OP_PUT, 0, 0);
    push_random(280);

    // smallest alphabet and one run bin; values of 2 and up flagged
    start_phase(2, 1, 61, 0);
    push_item(OP_PUT, 2, 0);
    push_item(OP_PUT, 1, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_PUT, 0, 0);
    push_item(OP_PUT, 1, 0);
    push_item(OP_READ, 0, 2);
    push_random(280);

    // out-of-range registers clamp; long receiver hold-off fills the block
    start_phase(511, 31, 0, 61);
    hold_asked++;
    push_random(280);

    start_phase(100, 5, 14, 14);
    push_random(280);

    start_phase(1, 0, 0, 0);
    push_random(280);

    start_phase(17, 16, 14, 14);
    push_random(280);

    wait_drained();
    repeat (20) @(negedge clk);
    if (expected_counts.size() != 0) begin
      errors++;
      $display("%0t: %0d transfers never arrived", $time, expected_counts.size());
    end
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/zrsh_pkg.sv
rtl/zrsh_if.sv
rtl/zrsh_ram.sv
rtl/zrsh_front.sv
rtl/zrsh_queue.sv
rtl/zrsh_back.sv
rtl/zero_run_symbol_histogram_top.sv
tb/zero_run_symbol_histogram_top_tb.sv
